// ----- rtl/lca_pkg.sv -----
package lca_pkg;

	localparam int NODE_W = 14;
	localparam logic [NODE_W-1:0] DEPTH_MAX = 14'h3fff;
	localparam logic [NODE_W-1:0] DEPTH_ROOT = 14'd1;

	typedef enum logic [1:0] {
		OUT_ZERO = 2'd0,
		OUT_U    = 2'd1,
		OUT_RD   = 2'd2
	} out_src_t;

	typedef struct packed {
		logic     load;
		logic     dep_rd;
		logic     dep_rd_v;
		logic     dep_wr;
		logic     anc_rd;
		logic     anc_rd_v;
		logic     anc_wr;
		logic     anc_wr_next;
		logic     cap_du;
		logic     swap;
		logic     u_take_rd;
		logic     cap_au;
		logic     take_pair;
		logic     lvl_inc;
		logic     lvl_dec;
		logic     lvl_top;
		logic     emit;
		out_src_t out_src;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic n_zero;
		logic u_zero;
		logic v_zero;
		logic u_eq_v;
		logic diff_bit;
		logic lvl_last;
		logic lvl_next_last;
		logic lvl_zero;
	} status_t;

endpackage

// ----- rtl/lca_ctrl.sv -----
module lca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lca_pkg::status_t sts,
	output lca_pkg::cmd_t    cmd,
	output logic            busy
);
	import lca_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_DISP   = 17'h00002,
		S_I_DRD  = 17'h00004,
		S_I_DWR  = 17'h00008,
		S_I_ARD  = 17'h00010,
		S_I_AWR  = 17'h00020,
		S_Q_DU   = 17'h00040,
		S_Q_DV   = 17'h00080,
		S_Q_SWAP = 17'h00100,
		S_Q_LIFT = 17'h00200,
		S_Q_LFTW = 17'h00400,
		S_Q_CMP  = 17'h00800,
		S_Q_TOPU = 17'h01000,
		S_Q_TOPV = 17'h02000,
		S_Q_TOPC = 17'h04000,
		S_Q_FIN  = 17'h08000,
		S_Q_OUT  = 17'h10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_src = OUT_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.func) begin
					if (sts.u_zero || sts.v_zero) begin
						cmd.emit = 1'b1;
						cmd.out_src = OUT_ZERO;
						state_d = S_IDLE;
					end else begin
						state_d = S_Q_DU;
					end
				end else if (sts.n_zero) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_I_DRD;
				end
			end
			// insert: depth of parent, then level 0, then one level per read
			S_I_DRD: begin
				cmd.dep_rd = 1'b1;
				state_d = S_I_DWR;
			end
			S_I_DWR: begin
				cmd.dep_wr = 1'b1;
				cmd.anc_wr = 1'b1;
				state_d = S_I_ARD;
			end
			S_I_ARD: begin
				cmd.anc_rd = !sts.u_zero;
				state_d = S_I_AWR;
			end
			S_I_AWR: begin
				cmd.anc_wr = 1'b1;
				cmd.anc_wr_next = 1'b1;
				cmd.lvl_inc = 1'b1;
				state_d = sts.lvl_next_last ? S_IDLE : S_I_ARD;
			end
			S_Q_DU: begin
				cmd.dep_rd = 1'b1;
				state_d = S_Q_DV;
			end
			S_Q_DV: begin
				cmd.dep_rd = 1'b1;
				cmd.dep_rd_v = 1'b1;
				cmd.cap_du = 1'b1;
				state_d = S_Q_SWAP;
			end
			S_Q_SWAP: begin
				cmd.swap = 1'b1;
				state_d = S_Q_LIFT;
			end
			S_Q_LIFT: begin
				if (sts.diff_bit) begin
					cmd.anc_rd = 1'b1;
					state_d = S_Q_LFTW;
				end else if (sts.lvl_last) begin
					state_d = S_Q_CMP;
				end else begin
					cmd.lvl_inc = 1'b1;
				end
			end
			S_Q_LFTW: begin
				cmd.u_take_rd = 1'b1;
				if (sts.lvl_last) begin
					state_d = S_Q_CMP;
				end else begin
					cmd.lvl_inc = 1'b1;
					state_d = S_Q_LIFT;
				end
			end
			S_Q_CMP: begin
				if (sts.u_eq_v) begin
					cmd.emit = 1'b1;
					cmd.out_src = OUT_U;
					state_d = S_IDLE;
				end else begin
					cmd.lvl_top = 1'b1;
					state_d = S_Q_TOPU;
				end
			end
			S_Q_TOPU: begin
				cmd.anc_rd = 1'b1;
				state_d = S_Q_TOPV;
			end
			S_Q_TOPV: begin
				cmd.cap_au = 1'b1;
				cmd.anc_rd = 1'b1;
				cmd.anc_rd_v = 1'b1;
				state_d = S_Q_TOPC;
			end
			S_Q_TOPC: begin
				cmd.take_pair = 1'b1;
				if (sts.lvl_zero) begin
					state_d = S_Q_FIN;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_d = S_Q_TOPU;
				end
			end
			S_Q_FIN: begin
				cmd.anc_rd = 1'b1;
				state_d = S_Q_OUT;
			end
			S_Q_OUT: begin
				cmd.emit = 1'b1;
				cmd.out_src = OUT_RD;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/lca_dpath.sv -----
module lca_dpath #(
	parameter int LEVELS = 14
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lca_pkg::cmd_t            cmd,
	output lca_pkg::status_t         sts,
	input  logic                     func,
	input  logic [lca_pkg::NODE_W-1:0] node,
	input  logic [lca_pkg::NODE_W-1:0] parent,
	input  logic [lca_pkg::NODE_W-1:0] query_node,
	output logic [lca_pkg::NODE_W-1:0] ancestor,
	output logic                     done
);
	import lca_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int AW = NODE_W + LW;
	localparam int ND = 1 << NODE_W;
	localparam int AD = 1 << AW;
	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

	logic [NODE_W-1:0] dep_mem [ND];
	logic [NODE_W-1:0] anc_mem [AD];

	logic              func_q;
	logic [NODE_W-1:0] n_q, u_q, v_q, du_q, au_q, diff_q;
	logic [LW-1:0]     lvl_q;
	logic [NODE_W-1:0] dep_rd_q, anc_rd_q;
	logic [NODE_W-1:0] res_q;
	logic              done_q;

	logic [NODE_W-1:0] dep_addr, dep_wdata, anc_wdata, nxt, diff_sh;
	logic [AW-1:0]     anc_raddr, anc_waddr;
	logic [LW-1:0]     lvl_p1;

	assign lvl_p1 = lvl_q + LW'(1);
	assign nxt = (u_q == '0) ? '0 : anc_rd_q;

	assign dep_addr = cmd.dep_rd_v ? v_q : u_q;
	assign dep_wdata = (u_q == '0) ? DEPTH_ROOT :
		((dep_rd_q == DEPTH_MAX) ? DEPTH_MAX : dep_rd_q + NODE_W'(1));

	assign anc_raddr = {(cmd.anc_rd_v ? v_q : u_q), lvl_q};
	assign anc_waddr = {n_q, (cmd.anc_wr_next ? lvl_p1 : lvl_q)};
	assign anc_wdata = cmd.anc_wr_next ? nxt : u_q;

	always_ff @(posedge clk) begin
		if (cmd.dep_wr) begin
			dep_mem[n_q] <= dep_wdata;
		end
		if (cmd.dep_rd) begin
			dep_rd_q <= dep_mem[dep_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.anc_wr) begin
			anc_mem[anc_waddr] <= anc_wdata;
		end
		if (cmd.anc_rd) begin
			anc_rd_q <= anc_mem[anc_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			n_q <= node;
			u_q <= func ? node : parent;
			v_q <= query_node;
		end
		if (cmd.cap_du) begin
			du_q <= dep_rd_q;
		end
		// put the deeper node in u
		if (cmd.swap) begin
			if (du_q < dep_rd_q) begin
				u_q <= v_q;
				v_q <= u_q;
				diff_q <= dep_rd_q - du_q;
			end else begin
				diff_q <= du_q - dep_rd_q;
			end
		end
		if (cmd.anc_wr_next) begin
			u_q <= nxt;
		end
		if (cmd.u_take_rd) begin
			u_q <= anc_rd_q;
		end
		if (cmd.cap_au) begin
			au_q <= anc_rd_q;
		end
		if (cmd.take_pair && (au_q != anc_rd_q)) begin
			u_q <= au_q;
			v_q <= anc_rd_q;
		end
		if (cmd.emit) begin
			case (cmd.out_src)
				OUT_U:   res_q <= u_q;
				OUT_RD:  res_q <= anc_rd_q;
				default: res_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load) begin
				lvl_q <= '0;
			end else if (cmd.lvl_top) begin
				lvl_q <= LVL_TOP;
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_p1;
			end else if (cmd.lvl_dec) begin
				lvl_q <= lvl_q - LW'(1);
			end
		end
	end

	assign diff_sh = diff_q >> lvl_q;

	always_comb begin
		sts.func = func_q;
		sts.n_zero = (n_q == '0);
		sts.u_zero = (u_q == '0);
		sts.v_zero = (v_q == '0);
		sts.u_eq_v = (u_q == v_q);
		sts.diff_bit = diff_sh[0];
		sts.lvl_last = (lvl_q == LVL_TOP);
		sts.lvl_next_last = (lvl_p1 == LVL_TOP);
		sts.lvl_zero = (lvl_q == '0);
	end

	assign ancestor = res_q;
	assign done = done_q;

endmodule

// ----- rtl/tree_lca_binary_lifting_top.sv -----
// Lowest common ancestor over a rooted forest by binary lifting.
// Command channel: present func/node/parent/query_node with start; the item
// is taken at a clock edge where start is high and busy is low.
//   func 0: insert node under parent (parent 0 makes a root). Parents go in
//           before their children. No result beat.
//   func 1: query node and query_node; one result beat on ancestor, marked by
//           done for exactly one cycle, 0 when the nodes share no tree.
// Insert: a depth write and the level-0 ancestor write, then one ancestor-table
// read and write per further level; no new command is taken until it is through.
// Query: the depth lift reads the ancestor table for each set bit of the depth
// difference and steps over each clear bit, and the joint lift makes two reads
// per level on the single ancestor-table port plus the compare.
// A query with a null node answers straight from the dispatch state, with no table reads.
// The result sits in an output register, so busy drops while done is shown
// and the next command can be taken in that same cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset clears the controller, level counter and strobe only. Depth and ancestor
// memories are not cleared; a query must only touch nodes already inserted.
module tree_lca_binary_lifting_top #(
	parameter int LEVELS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       func,
	input  logic [lca_pkg::NODE_W-1:0] node,
	input  logic [lca_pkg::NODE_W-1:0] parent,
	input  logic [lca_pkg::NODE_W-1:0] query_node,
	output logic [lca_pkg::NODE_W-1:0] ancestor,
	output logic                       done
);
	import lca_pkg::*;

	cmd_t    cmd;
	status_t sts;

	lca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lca_dpath #(
		.LEVELS (LEVELS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.node       (node),
		.parent     (parent),
		.query_node (query_node),
		.ancestor   (ancestor),
		.done       (done)
	);

endmodule

// ----- rtl/lca_checker.sv -----
module lca_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic done
);

	// a result beat only leaves as the engine goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("taken command did not start work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result beats");

	a_insert_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !func) |=> ##1 !done)
		else $error("result beat after insert");

endmodule

bind tree_lca_binary_lifting_top lca_checker u_lca_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.done   (done)
);

// ----- test/lca_result_checker.sv -----
module lca_result_checker #(
	parameter int LEVELS = 14,
	parameter bit QUERY_CODE = 1'b1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       func,
	input  logic [lca_pkg::NODE_W-1:0] node,
	input  logic [lca_pkg::NODE_W-1:0] parent,
	input  logic [lca_pkg::NODE_W-1:0] query_node,
	input  logic [lca_pkg::NODE_W-1:0] ancestor,
	input  logic                       done,
	output int                         fail_count,
	output int                         due_count,
	output int                         checked_count
);

	localparam int NODE_SPAN = 1 << lca_pkg::NODE_W;

	typedef logic [lca_pkg::NODE_W-1:0] node_t;

	bit [lca_pkg::NODE_W-1:0] depth_of [NODE_SPAN];
	bit [lca_pkg::NODE_W-1:0] hop [NODE_SPAN][LEVELS];
	node_t lca_due [$];
	node_t want;
	int fails = 0;
	int checked = 0;

	// Levels are rebuilt in order, so a self parent folds every level onto the node.
	function automatic void graft_node(node_t n, node_t p);
		node_t mid;
		bit [lca_pkg::NODE_W-1:0] d;
		if (n == '0)
			return;
		if (p == '0)
			d = lca_pkg::DEPTH_ROOT;
		else
			d = (depth_of[p] == lca_pkg::DEPTH_MAX) ? lca_pkg::DEPTH_MAX :
				depth_of[p] + lca_pkg::NODE_W'(1);
		depth_of[n] = d;
		hop[n][0] = p;
		for (int k = 1; k < LEVELS; k++) begin
			mid = hop[n][k-1];
			hop[n][k] = (mid != '0) ? hop[mid][k-1] : '0;
		end
	endfunction

	function automatic node_t common_ancestor(node_t a, node_t b);
		node_t u, v, au, av;
		bit [lca_pkg::NODE_W-1:0] gap;
		if (a == '0 || b == '0)
			return '0;
		if (depth_of[a] < depth_of[b]) begin
			u = b;
			v = a;
			gap = depth_of[b] - depth_of[a];
		end else begin
			u = a;
			v = b;
			gap = depth_of[a] - depth_of[b];
		end
		for (int k = 0; k < LEVELS; k++) begin
			if (((gap >> k) & lca_pkg::NODE_W'(1)) != '0)
				u = hop[u][k];
		end
		if (u == v)
			return u;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			au = hop[u][k];
			av = hop[v][k];
			if (au != av) begin
				u = au;
				v = av;
			end
		end
		return hop[u][0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lca_due.delete();
			fail_count <= 0;
			due_count <= 0;
			checked_count <= 0;
		end else begin
			// retire the finished beat before taking a new command in the same edge
			if (done === 1'b1) begin
				if (lca_due.size() == 0) begin
					$display("%0t: ancestor %0d with no query waiting", $time, ancestor);
					fails++;
				end else begin
					want = lca_due.pop_front();
					checked++;
					if (ancestor !== want) begin
						$display("%0t: ancestor mismatch, expected %0d, got %0d",
							$time, want, ancestor);
						fails++;
					end
				end
			end else if (done !== 1'b0) begin
				$display("%0t: done unknown, expected 0 or 1, got %b", $time, done);
				fails++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				if (func == QUERY_CODE)
					lca_due.push_back(common_ancestor(node, query_node));
				else
					graft_node(node, parent);
			end
			fail_count <= fails;
			due_count <= lca_due.size();
			checked_count <= checked;
		end
	end

endmodule

// ----- test/tree_lca_binary_lifting_top_tb.sv -----
module tree_lca_binary_lifting_top_tb;

	localparam int LEVELS = 14;
	localparam bit OP_INSERT = 1'b0;
	localparam bit OP_QUERY = 1'b1;
	localparam int NODE_SPAN = 1 << lca_pkg::NODE_W;

	typedef logic [lca_pkg::NODE_W-1:0] node_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = OP_INSERT;
	node_t node = '0;
	node_t parent = '0;
	node_t query_node = '0;
	logic busy;
	logic done;
	node_t ancestor;
	int fail_count;
	int due_count;
	int checked_count;

	bit taken [NODE_SPAN];
	bit has_child [NODE_SPAN];
	node_t up_of [NODE_SPAN];
	node_t placed [$];
	node_t looped [$];
	bit idle_on = 1'b1;
	int inserts_sent = 0;
	int queries_sent = 0;

	always #1 clk = ~clk;

	tree_lca_binary_lifting_top #(.LEVELS(LEVELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.node(node),
		.parent(parent),
		.query_node(query_node),
		.ancestor(ancestor),
		.done(done)
	);

	lca_result_checker #(.LEVELS(LEVELS), .QUERY_CODE(OP_QUERY)) u_result_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.node(node),
		.parent(parent),
		.query_node(query_node),
		.ancestor(ancestor),
		.done(done),
		.fail_count(fail_count),
		.due_count(due_count),
		.checked_count(checked_count)
	);

	// Hold start until the block takes the beat; return on the accepting edge.
	task automatic issue(input logic f, input node_t n, input node_t p, input node_t q);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 99) < 30)
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		node <= n;
		parent <= p;
		query_node <= q;
		do @(posedge clk); while (busy !== 1'b0);
		if (f == OP_QUERY)
			queries_sent++;
		else
			inserts_sent++;
	endtask

	function automatic node_t fresh_node();
		node_t n;
		do n = node_t'($urandom_range(1, NODE_SPAN - 1)); while (taken[n]);
		taken[n] = 1'b1;
		return n;
	endfunction

	function automatic node_t any_placed();
		return placed[$urandom_range(0, placed.size() - 1)];
	endfunction

	function automatic node_t any_node();
		return node_t'($urandom_range(0, NODE_SPAN - 1));
	endfunction

	task automatic plant(input node_t n, input node_t p);
		taken[n] = 1'b1;
		issue(OP_INSERT, n, p, any_node());
		placed.push_back(n);
		up_of[n] = p;
		if (p != '0)
			has_child[p] = 1'b1;
	endtask

	task automatic ask(input node_t a, input node_t b);
		issue(OP_QUERY, a, any_node(), b);
	endtask

	// Favor the newest nodes as parents so that chains get deep.
	task automatic grow();
		node_t p;
		int r, back;
		r = $urandom_range(0, 99);
		back = (placed.size() > 3) ? 3 : placed.size();
		if (placed.size() == 0 || r < 6)
			p = '0;
		else if (r < 60)
			p = placed[placed.size() - 1 - $urandom_range(0, back - 1)];
		else
			p = any_placed();
		plant(fresh_node(), p);
	endtask

	// Only a leaf may point to itself: its subtree would otherwise go stale.
	task automatic loop_leaf();
		int i;
		node_t n;
		for (int tries = 0; tries < 20; tries++) begin
			i = $urandom_range(0, placed.size() - 1);
			if (!has_child[placed[i]] && placed.size() > 4) begin
				n = placed[i];
				placed.delete(i);
				issue(OP_INSERT, n, n, any_node());
				looped.push_back(n);
				return;
			end
		end
		ask(any_placed(), any_placed());
	endtask

	initial begin
		node_t a, b, s, c, g;
		int pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plant(14'd16383, 14'd0);
		plant(14'd1, 14'd16383);
		plant(14'd8192, 14'd1);
		plant(14'd5461, 14'd8192);
		plant(14'd10922, 14'd1);
		plant(14'd2, 14'd0);
		plant(14'd3, 14'd2);
		ask(14'd5461, 14'd10922);
		ask(14'd10922, 14'd5461);
		ask(14'd5461, 14'd16383);
		ask(14'd16383, 14'd5461);
		ask(14'd5461, 14'd5461);
		ask(14'd5461, 14'd3);
		ask(14'd0, 14'd5461);
		ask(14'd5461, 14'd0);
		ask(14'd0, 14'd0);
		issue(OP_INSERT, 14'd0, 14'd16383, 14'd16383);
		issue(OP_INSERT, 14'd8192, 14'd1, 14'd0);
		ask(14'd5461, 14'd10922);
		taken[4096] = 1'b1;
		has_child[3] = 1'b1;
		issue(OP_INSERT, 14'd4096, 14'd3, 14'd16383);
		issue(OP_INSERT, 14'd4096, 14'd4096, 14'd0);
		looped.push_back(14'd4096);
		ask(14'd4096, 14'd4096);

		// Grow one long chain and query its tip, all beats back to back.
		idle_on = 1'b0;
		s = any_placed();
		for (int i = 0; i < 60; i++) begin
			c = fresh_node();
			plant(c, s);
			s = c;
		end
		for (int i = 0; i < 60; i++) begin
			g = any_placed();
			ask(s, g);
		end
		idle_on = 1'b1;

		for (int i = 0; i < 1110; i++) begin
			pick = $urandom_range(0, 99);
			if (placed.size() < 8 || pick < 45) begin
				grow();
			end else if (pick < 80) begin
				a = any_placed();
				b = ($urandom_range(0, 19) == 0) ? a : any_placed();
				ask(a, b);
			end else if (pick < 84) begin
				case ($urandom_range(0, 2))
					0: ask(14'd0, any_placed());
					1: ask(any_placed(), 14'd0);
					default: ask(14'd0, 14'd0);
				endcase
			end else if (pick < 87) begin
				issue(OP_INSERT, 14'd0, any_node(), any_node());
			end else if (pick < 93) begin
				a = any_placed();
				issue(OP_INSERT, a, up_of[a], any_node());
			end else if (pick < 95) begin
				loop_leaf();
			end else if (looped.size() > 0) begin
				a = looped[$urandom_range(0, looped.size() - 1)];
				ask(a, a);
			end else begin
				ask(any_placed(), any_placed());
			end
		end
		start <= 1'b0;

		while (due_count != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("sent %0d inserts and %0d queries, %0d answers compared",
			inserts_sent, queries_sent, checked_count);
		$display("forest of %0d live nodes, %0d self loops, one 60-deep chain fed back to back",
			placed.size(), looped.size());
		if (fail_count == 0 && due_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout waiting on the block");
		$display("status: fail");
		$finish;
	end

endmodule
